// ===== rtl/core/chd_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and saturating helpers for the cubic root solver.
// Used by chd_mul, chd_div and cubic_roots_halley_deflation_top; no dependencies.
package chd_pkg;

  localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;
  localparam logic signed [63:0] DIV_THREE = 64'sd3;

  // ceil(2^65 / 3): q = (m * RECIP3) >> 65 is m / 3 for any 64-bit m
  localparam logic [63:0] RECIP3 = 64'hAAAA_AAAA_AAAA_AAAB;

  localparam int TOL_W      = 41;
  localparam int ITER_W     = 8;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER  = 8'd1;

  localparam logic [TOL_W-1:0]  TOL_RESET  = 41'd1024;
  localparam logic [ITER_W-1:0] ITER_RESET = 8'd50;

  localparam logic [6:0] DIV_STEPS  = 7'd127;
  localparam logic [6:0] SQRT_STEPS = 7'd63;

  typedef struct packed {
    logic signed [63:0] coef_quadratic;
    logic signed [63:0] coef_linear;
    logic signed [63:0] coef_constant;
  } in_word_t;

  typedef struct packed {
    logic signed [63:0] root_first;
    logic signed [63:0] root_second_re;
    logic signed [63:0] root_second_im;
    logic signed [63:0] root_third_re;
    logic signed [63:0] root_third_im;
    logic               converged;
    logic [7:0]         steps_used;
    logic               fault;
  } out_word_t;

  // value with its saturation flag
  typedef struct packed {
    logic               ovf;
    logic signed [63:0] val;
  } sval_t;

  typedef struct packed {
    logic               go;
    logic               div3;   // integer a / 3, truncated toward zero; b unused
    logic signed [63:0] a;
    logic signed [63:0] b;
  } mul_req_t;

  typedef struct packed {
    logic               done;
    logic               ovf;
    logic signed [63:0] p;
  } mul_rsp_t;

  typedef struct packed {
    logic               go;
    logic               sqrt;   // square root of n instead of n / d
    logic signed [63:0] n;
    logic signed [63:0] d;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic               ovf;
    logic signed [63:0] q;
  } div_rsp_t;

  function automatic logic [63:0] mag64(input logic signed [63:0] x);
    logic [63:0] u;
    u = x;
    return u[63] ? (64'd0 - u) : u;
  endfunction

  function automatic sval_t from_mag(input logic [63:0] m, input logic neg);
    sval_t r;
    r.ovf = 1'b0;
    if (neg) begin
      if (m > 64'h8000_0000_0000_0000) begin
        r.ovf = 1'b1;
        r.val = S64_MIN;
      end else begin
        r.val = 64'd0 - m;
      end
    end else if (m[63]) begin
      r.ovf = 1'b1;
      r.val = S64_MAX;
    end else begin
      r.val = m;
    end
    return r;
  endfunction

  function automatic sval_t sadd(input logic signed [63:0] a, input logic signed [63:0] b);
    logic [64:0] s;
    sval_t r;
    s = {a[63], a} + {b[63], b};
    r.ovf = s[64] ^ s[63];
    r.val = r.ovf ? (s[64] ? S64_MIN : S64_MAX) : s[63:0];
    return r;
  endfunction

  function automatic sval_t ssub(input logic signed [63:0] a, input logic signed [63:0] b);
    logic [64:0] s;
    sval_t r;
    s = {a[63], a} - {b[63], b};
    r.ovf = s[64] ^ s[63];
    r.val = r.ovf ? (s[64] ? S64_MIN : S64_MAX) : s[63:0];
    return r;
  endfunction

  // halve and quarter, truncated toward zero
  function automatic logic signed [63:0] div2_tz(input logic signed [63:0] x);
    logic signed [63:0] y;
    y = x[63] ? (x + 64'sd1) : x;
    return y >>> 1;
  endfunction

  function automatic logic signed [63:0] div4_tz(input logic signed [63:0] x);
    logic signed [63:0] y;
    y = x[63] ? (x + 64'sd3) : x;
    return y >>> 2;
  endfunction

endpackage

// ===== rtl/core/chd_mul.sv =====
`timescale 1ns / 1ps
// Fixed-point signed multiplier: four 32x32 partial products, one per cycle.
// Also divides by three through a reciprocal product. Depends on chd_pkg.
module chd_mul #(
  parameter int FRAC_BITS = 40
) (
  input  logic             clk,
  input  logic             rst_n,
  input  chd_pkg::mul_req_t req,
  output chd_pkg::mul_rsp_t rsp
);
  import chd_pkg::*;

  typedef enum logic [1:0] {M_IDLE, M_RUN, M_FIN} mst_t;

  mst_t         st_r, st_nxt;
  logic [63:0]  ma_r, ma_nxt, mb_r, mb_nxt;
  logic         neg_r, neg_nxt;
  logic         d3_r, d3_nxt;
  logic [127:0] acc_r, acc_nxt;
  logic [1:0]   k_r, k_nxt;
  mul_rsp_t     rsp_r, rsp_nxt;

  logic [63:0]  pp;
  logic [6:0]   shamt;
  logic [63:0]  q3;
  sval_t        fm;

  // partial product for the current digit pair
  assign pp    = ma_r[{k_r[1], 5'd0} +: 32] * mb_r[{k_r[0], 5'd0} +: 32];
  assign shamt = {k_r[1] & k_r[0], k_r[1] ^ k_r[0], 5'd0};
  assign q3    = {1'b0, acc_r[127:65]};
  assign fm    = from_mag(acc_r[63+FRAC_BITS:FRAC_BITS], neg_r);

  always_comb begin
    st_nxt  = st_r;
    ma_nxt  = ma_r;
    mb_nxt  = mb_r;
    neg_nxt = neg_r;
    d3_nxt  = d3_r;
    acc_nxt = acc_r;
    k_nxt   = k_r;
    rsp_nxt = rsp_r;
    rsp_nxt.done = 1'b0;
    case (st_r)
      M_IDLE: begin
        if (req.go) begin
          ma_nxt  = mag64(req.a);
          mb_nxt  = req.div3 ? RECIP3 : mag64(req.b);
          neg_nxt = req.div3 ? req.a[63] : (req.a[63] ^ req.b[63]);
          d3_nxt  = req.div3;
          acc_nxt = '0;
          k_nxt   = 2'd0;
          st_nxt  = M_RUN;
        end
      end
      M_RUN: begin
        acc_nxt = acc_r + ({64'd0, pp} << shamt);
        k_nxt   = k_r + 2'd1;
        if (k_r == 2'd3) st_nxt = M_FIN;
      end
      M_FIN: begin
        // drop the fraction bits, saturate if the integer part overflows (not for a division by three)
        rsp_nxt.done = 1'b1;
        if (d3_r) begin
          rsp_nxt.ovf = 1'b0;
          rsp_nxt.p   = neg_r ? (64'd0 - q3) : q3;
        end else if (acc_r[127:64+FRAC_BITS] != '0) begin
          rsp_nxt.ovf = 1'b1;
          rsp_nxt.p   = neg_r ? S64_MIN : S64_MAX;
        end else begin
          rsp_nxt.ovf = fm.ovf;
          rsp_nxt.p   = fm.val;
        end
        st_nxt = M_IDLE;
      end
      default: st_nxt = M_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    ma_r      <= ma_nxt;
    mb_r      <= mb_nxt;
    neg_r     <= neg_nxt;
    d3_r      <= d3_nxt;
    acc_r     <= acc_nxt;
    k_r       <= k_nxt;
    rsp_r.ovf <= rsp_nxt.ovf;
    rsp_r.p   <= rsp_nxt.p;
    if (!rst_n) begin
      st_r       <= M_IDLE;
      rsp_r.done <= 1'b0;
    end else begin
      st_r       <= st_nxt;
      rsp_r.done <= rsp_nxt.done;
    end
  end

  assign rsp = rsp_r;

endmodule

// ===== rtl/core/chd_div.sv =====
`timescale 1ns / 1ps
// Shared radix-2 divider and radix-2 square root unit, one digit per cycle.
// Depends on chd_pkg for request/response words and saturation helpers.
module chd_div #(
  parameter int FRAC_BITS = 40
) (
  input  logic             clk,
  input  logic             rst_n,
  input  chd_pkg::div_req_t req,
  output chd_pkg::div_rsp_t rsp
);
  import chd_pkg::*;

  typedef enum logic [1:0] {D_IDLE, D_RUN, D_FIN} dst_t;

  dst_t         st_r, st_nxt;
  logic [127:0] sh_r, sh_nxt;
  logic [66:0]  rem_r, rem_nxt;
  logic [63:0]  root_r, root_nxt;
  logic [63:0]  dm_r, dm_nxt;
  logic [6:0]   cnt_r, cnt_nxt;
  logic         neg_r, neg_nxt;
  logic         sq_r, sq_nxt;
  logic         zden_r, zden_nxt;
  logic signed [63:0] zsat_r, zsat_nxt;
  div_rsp_t     rsp_r, rsp_nxt;

  logic [64:0]  drem;
  logic [66:0]  srem;
  logic [66:0]  trial;
  sval_t        fm;

  assign drem  = {rem_r[63:0], sh_r[127]};
  assign srem  = {rem_r[64:0], sh_r[127:126]};
  assign trial = {1'b0, root_r, 2'b01};
  assign fm    = from_mag(sh_r[63:0], neg_r);

  always_comb begin
    st_nxt   = st_r;
    sh_nxt   = sh_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    dm_nxt   = dm_r;
    cnt_nxt  = cnt_r;
    neg_nxt  = neg_r;
    sq_nxt   = sq_r;
    zden_nxt = zden_r;
    zsat_nxt = zsat_r;
    rsp_nxt  = rsp_r;
    rsp_nxt.done = 1'b0;
    case (st_r)
      D_IDLE: begin
        if (req.go) begin
          rem_nxt  = '0;
          root_nxt = '0;
          sq_nxt   = req.sqrt;
          zden_nxt = 1'b0;
          neg_nxt  = req.n[63] ^ req.d[63];
          dm_nxt   = mag64(req.d);
          zsat_nxt = req.n[63] ? S64_MIN : ((req.n != 64'sd0) ? S64_MAX : 64'sd0);
          st_nxt   = D_RUN;
          if (req.sqrt) begin
            sh_nxt  = (req.n > 64'sd0) ? ({64'd0, req.n} << FRAC_BITS) : '0;
            cnt_nxt = SQRT_STEPS;
          end else begin
            sh_nxt  = {64'd0, mag64(req.n)} << FRAC_BITS;
            cnt_nxt = DIV_STEPS;
            if (req.d == 64'sd0) begin
              zden_nxt = 1'b1;
              st_nxt   = D_FIN;
            end
          end
        end
      end
      D_RUN: begin
        if (sq_r) begin
          // one root bit per cycle from two radicand bits
          if (srem >= trial) begin
            rem_nxt  = srem - trial;
            root_nxt = {root_r[62:0], 1'b1};
          end else begin
            rem_nxt  = srem;
            root_nxt = {root_r[62:0], 1'b0};
          end
          sh_nxt = {sh_r[125:0], 2'b00};
        end else begin
          // restoring step, quotient bit enters at the bottom
          if (drem >= {1'b0, dm_r}) begin
            rem_nxt = {2'b00, drem - {1'b0, dm_r}};
            sh_nxt  = {sh_r[126:0], 1'b1};
          end else begin
            rem_nxt = {2'b00, drem};
            sh_nxt  = {sh_r[126:0], 1'b0};
          end
        end
        cnt_nxt = cnt_r - 7'd1;
        if (cnt_r == 7'd0) st_nxt = D_FIN;
      end
      D_FIN: begin
        rsp_nxt.done = 1'b1;
        if (sq_r) begin
          rsp_nxt.ovf = 1'b0;
          rsp_nxt.q   = root_r;
        end else if (zden_r) begin
          rsp_nxt.ovf = 1'b1;
          rsp_nxt.q   = zsat_r;
        end else if (sh_r[127:64] != '0) begin
          rsp_nxt.ovf = 1'b1;
          rsp_nxt.q   = neg_r ? S64_MIN : S64_MAX;
        end else begin
          rsp_nxt.ovf = fm.ovf;
          rsp_nxt.q   = fm.val;
        end
        st_nxt = D_IDLE;
      end
      default: st_nxt = D_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    sh_r      <= sh_nxt;
    rem_r     <= rem_nxt;
    root_r    <= root_nxt;
    dm_r      <= dm_nxt;
    cnt_r     <= cnt_nxt;
    neg_r     <= neg_nxt;
    sq_r      <= sq_nxt;
    zden_r    <= zden_nxt;
    zsat_r    <= zsat_nxt;
    rsp_r.ovf <= rsp_nxt.ovf;
    rsp_r.q   <= rsp_nxt.q;
    if (!rst_n) begin
      st_r       <= D_IDLE;
      rsp_r.done <= 1'b0;
    end else begin
      st_r       <= st_nxt;
      rsp_r.done <= rsp_nxt.done;
    end
  end

  assign rsp = rsp_r;

endmodule

// ===== rtl/core/cubic_roots_halley_deflation_top.sv =====
`timescale 1ns / 1ps
// Cubic root solver top level: sequencer, working registers and config registers.
// Depends on chd_pkg, chd_mul and chd_div.

// Solves Z^3 + a2 Z^2 + a1 Z + a0 in signed fixed point (FRAC_BITS fraction bits).
// Raise start with a coefficient word while busy is low; the word is taken at that
// edge and busy stays high until the result. The result word appears on out_word for
// exactly one cycle with out_valid high and must be captured then: there is no
// back-pressure. All arithmetic runs on one shared multiplier, which also divides by three,
// and one shared divider/square-root unit, the slower of the two. An item runs setup,
// Halley steps and deflation, plus a cube-root search when the start point needs it.
// Configuration writes are always accepted (cfg_ready is tied high) and must only be
// made while busy is low.
module cubic_roots_halley_deflation_top #(
  parameter int FRAC_BITS = 40
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  chd_pkg::in_word_t                   in_word,
  output logic                                out_valid,
  output chd_pkg::out_word_t                  out_word,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [chd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [chd_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import chd_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE, ST_DISC, ST_INFL, ST_PZ2, ST_PZ3, ST_PA2, ST_PA1, ST_SQD, ST_THIRD,
    ST_CBSQ, ST_CBCU, ST_LOOP, ST_HDF, ST_HM, ST_HD2, ST_HNUM, ST_HDEN, ST_HFD,
    ST_HDIV, ST_FC1, ST_FC2, ST_FC11, ST_FDS, ST_FSQ
  } state_t;

  typedef enum logic {RET_START, RET_HALLEY} ret_t;

  state_t state_r, state_nxt;
  ret_t   ret_r, ret_nxt;

  logic [TOL_W-1:0]  tol_r, tol_nxt;
  logic [ITER_W-1:0] max_iter_r, max_iter_nxt;
  logic [ITER_W-1:0] it_r, it_nxt;
  logic              conv_r, conv_nxt;
  logic              fault_r, fault_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_word_t         out_word_r, out_word_nxt;

  logic signed [63:0] a2_r, a2_nxt, a1_r, a1_nxt, a0_r, a0_nxt;
  logic signed [63:0] z_r, z_nxt, zi_r, zi_nxt, d_r, d_nxt, pz_r, pz_nxt;
  logic signed [63:0] z2_r, z2_nxt, f_r, f_nxt, fz_r, fz_nxt;
  logic signed [63:0] df_r, df_nxt, d2f_r, d2f_nxt, zz_r, zz_nxt, a2x2_r, a2x2_nxt;
  logic signed [63:0] num_r, num_nxt, den_r, den_nxt;
  logic signed [63:0] c1_r, c1_nxt, c2_r, c2_nxt, half_r, half_nxt;
  logic [63:0]        cb_r, cb_nxt, cb_m_r, cb_m_nxt;
  logic [5:0]         cb_bit_r, cb_bit_nxt;
  logic               cb_ovf_r, cb_ovf_nxt;

  mul_req_t mul_req_r, mul_req_nxt;
  div_req_t div_req_r, div_req_nxt;
  mul_rsp_t mul_rsp;
  div_rsp_t div_rsp;

  logic [63:0] c_cur;

  // trial cube-root value for the current bit
  assign c_cur = cb_r | (64'd1 << cb_bit_r);

  chd_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mul_req_r),
    .rsp   (mul_rsp)
  );

  chd_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req_r),
    .rsp   (div_rsp)
  );

  always_comb begin
    sval_t       s_a, s_b, s_c;
    logic        flt;
    logic        ok;
    logic [63:0] rnew, cnext, m;
    logic signed [63:0] cr;

    s_a = '0;
    s_b = '0;
    s_c = '0;
    flt = 1'b0;
    ok  = 1'b0;
    rnew  = '0;
    cnext = '0;
    m     = '0;
    cr    = '0;

    state_nxt    = state_r;
    ret_nxt      = ret_r;
    tol_nxt      = tol_r;
    max_iter_nxt = max_iter_r;
    it_nxt       = it_r;
    conv_nxt     = conv_r;
    fault_nxt    = fault_r;
    out_word_nxt = out_word_r;
    out_valid_nxt = 1'b0;
    a2_nxt = a2_r;  a1_nxt = a1_r;  a0_nxt = a0_r;
    z_nxt = z_r;    zi_nxt = zi_r;  d_nxt = d_r;    pz_nxt = pz_r;
    z2_nxt = z2_r;  f_nxt = f_r;    fz_nxt = fz_r;
    df_nxt = df_r;  d2f_nxt = d2f_r; zz_nxt = zz_r; a2x2_nxt = a2x2_r;
    num_nxt = num_r; den_nxt = den_r;
    c1_nxt = c1_r;  c2_nxt = c2_r;  half_nxt = half_r;
    cb_nxt = cb_r;  cb_m_nxt = cb_m_r; cb_bit_nxt = cb_bit_r; cb_ovf_nxt = cb_ovf_r;
    mul_req_nxt    = mul_req_r;
    mul_req_nxt.go = 1'b0;
    div_req_nxt    = div_req_r;
    div_req_nxt.go = 1'b0;

    // config writes
    if (cfg_valid) begin
      case (cfg_index)
        REG_TOLERANCE: tol_nxt      = cfg_data[TOL_W-1:0];
        REG_MAX_ITER:  max_iter_nxt = cfg_data[ITER_W-1:0];
        default: ;
      endcase
    end

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          a2_nxt    = in_word.coef_quadratic;
          a1_nxt    = in_word.coef_linear;
          a0_nxt    = in_word.coef_constant;
          fault_nxt = 1'b0;
          it_nxt    = '0;
          conv_nxt  = 1'b0;
          mul_req_nxt = '{go: 1'b1, div3: 1'b0, a: in_word.coef_quadratic,
                          b: in_word.coef_quadratic};
          state_nxt = ST_DISC;
        end
      end
      // discriminant a2^2 - 3 a1, then start a2 / 3
      ST_DISC: begin
        if (mul_rsp.done) begin
          s_a = sadd(a1_r, a1_r);
          s_b = sadd(s_a.val, a1_r);
          s_c = ssub(mul_rsp.p, s_b.val);
          flt = mul_rsp.ovf | s_a.ovf | s_b.ovf | s_c.ovf;
          d_nxt = s_c.val;
          mul_req_nxt = '{go: 1'b1, div3: 1'b1, a: a2_r, b: 64'sd0};
          state_nxt = ST_INFL;
        end
      end
      // inflection point; evaluate the cubic there unless d < 0
      ST_INFL: begin
        if (mul_rsp.done) begin
          zi_nxt = 64'sd0 - mul_rsp.p;
          if (d_r < 64'sd0) begin
            z_nxt     = 64'sd0 - mul_rsp.p;
            state_nxt = ST_LOOP;
          end else begin
            pz_nxt  = 64'sd0 - mul_rsp.p;
            ret_nxt = RET_START;
            mul_req_nxt = '{go: 1'b1, div3: 1'b0, a: 64'sd0 - mul_rsp.p,
                            b: 64'sd0 - mul_rsp.p};
            state_nxt = ST_PZ2;
          end
        end
      end
      // cubic evaluation at pz
      ST_PZ2: begin
        if (mul_rsp.done) begin
          flt    = mul_rsp.ovf;
          z2_nxt = mul_rsp.p;
          mul_req_nxt = '{go: 1'b1, div3: 1'b0, a: mul_rsp.p, b: pz_r};
          state_nxt = ST_PZ3;
        end
      end
      ST_PZ3: begin
        if (mul_rsp.done) begin
          flt   = mul_rsp.ovf;
          f_nxt = mul_rsp.p;
          mul_req_nxt = '{go: 1'b1, div3: 1'b0, a: a2_r, b: z2_r};
          state_nxt = ST_PA2;
        end
      end
      ST_PA2: begin
        if (mul_rsp.done) begin
          s_a   = sadd(f_r, mul_rsp.p);
          flt   = mul_rsp.ovf | s_a.ovf;
          f_nxt = s_a.val;
          mul_req_nxt = '{go: 1'b1, div3: 1'b0, a: a1_r, b: pz_r};
          state_nxt = ST_PA1;
        end
      end
      ST_PA1: begin
        if (mul_rsp.done) begin
          s_a   = sadd(f_r, mul_rsp.p);
          s_b   = sadd(s_a.val, a0_r);
          flt   = mul_rsp.ovf | s_a.ovf | s_b.ovf;
          f_nxt = s_b.val;
          if (ret_r == RET_HALLEY) begin
            state_nxt = ST_HDF;
          end else if (d_r > 64'sd0) begin
            div_req_nxt = '{go: 1'b1, sqrt: 1'b1, n: d_r, d: DIV_THREE};
            state_nxt = ST_SQD;
          end else begin
            // cube root of f at the inflection point, magnitude capped
            m = mag64(s_b.val);
            cb_m_nxt   = m[63] ? S64_MAX : m;
            cb_nxt     = '0;
            cb_bit_nxt = 6'd62;
            mul_req_nxt = '{go: 1'b1, div3: 1'b0, a: 64'sh4000_0000_0000_0000,
                            b: 64'sh4000_0000_0000_0000};
            state_nxt = ST_CBSQ;
          end
        end
      end
      // two thirds of the square root
      ST_SQD: begin
        if (div_rsp.done) begin
          s_a = sadd(div_rsp.q, div_rsp.q);
          flt = s_a.ovf;
          mul_req_nxt = '{go: 1'b1, div3: 1'b1, a: s_a.val, b: 64'sd0};
          state_nxt = ST_THIRD;
        end
      end
      ST_THIRD: begin
        if (mul_rsp.done) begin
          if (f_r > 64'sd0) begin
            s_a   = ssub(zi_r, mul_rsp.p);
            flt   = s_a.ovf;
            z_nxt = s_a.val;
          end else if (f_r < 64'sd0) begin
            s_a   = sadd(zi_r, mul_rsp.p);
            flt   = s_a.ovf;
            z_nxt = s_a.val;
          end else begin
            z_nxt = zi_r;
          end
          state_nxt = ST_LOOP;
        end
      end
      // cube root search: square the trial value
      ST_CBSQ: begin
        if (mul_rsp.done) begin
          cb_ovf_nxt  = mul_rsp.ovf;
          mul_req_nxt = '{go: 1'b1, div3: 1'b0, a: mul_rsp.p, b: c_cur};
          state_nxt   = ST_CBCU;
        end
      end
      // keep the trial bit if its cube stays within the magnitude
      ST_CBCU: begin
        if (mul_rsp.done) begin
          ok   = !(cb_ovf_r | mul_rsp.ovf) && (mul_rsp.p <= cb_m_r);
          rnew = ok ? c_cur : cb_r;
          cb_nxt = rnew;
          if (cb_bit_r == 6'd0) begin
            cr    = f_r[63] ? (64'sd0 - rnew) : rnew;
            s_a   = ssub(zi_r, cr);
            flt   = s_a.ovf;
            z_nxt = s_a.val;
            state_nxt = ST_LOOP;
          end else begin
            cb_bit_nxt = cb_bit_r - 6'd1;
            cnext = rnew | (64'd1 << (cb_bit_r - 6'd1));
            mul_req_nxt = '{go: 1'b1, div3: 1'b0, a: cnext, b: cnext};
            state_nxt = ST_CBSQ;
          end
        end
      end
      // next Halley step or deflation
      ST_LOOP: begin
        if (it_r < max_iter_r) begin
          it_nxt  = it_r + 8'd1;
          pz_nxt  = z_r;
          ret_nxt = RET_HALLEY;
          mul_req_nxt = '{go: 1'b1, div3: 1'b0, a: z_r, b: z_r};
          state_nxt = ST_PZ2;
        end else begin
          state_nxt = ST_FC1;
        end
      end
      // f' = 3 z^2 + 2 a2 z + a1 and f'' = 6 z + 2 a2
      ST_HDF: begin
        fz_nxt = f_r;
        s_a = sadd(z2_r, z2_r);
        s_b = sadd(s_a.val, z2_r);
        df_nxt = s_b.val;
        s_c = sadd(z_r, z_r);
        zz_nxt = s_c.val;
        flt = s_a.ovf | s_b.ovf | s_c.ovf;
        a2x2_nxt = sadd(a2_r, a2_r).val;
        flt = flt | sadd(a2_r, a2_r).ovf;
        mul_req_nxt = '{go: 1'b1, div3: 1'b0, a: sadd(a2_r, a2_r).val, b: z_r};
        state_nxt = ST_HM;
      end
      ST_HM: begin
        if (mul_rsp.done) begin
          s_a = sadd(df_r, mul_rsp.p);
          s_b = sadd(s_a.val, a1_r);
          df_nxt = s_b.val;
          flt = mul_rsp.ovf | s_a.ovf | s_b.ovf;
          s_c = sadd(zz_r, zz_r);
          flt = flt | s_c.ovf | sadd(s_c.val, zz_r).ovf;
          d2f_nxt = sadd(s_c.val, zz_r).val;
          state_nxt = ST_HD2;
        end
      end
      ST_HD2: begin
        s_a = sadd(d2f_r, a2x2_r);
        flt = s_a.ovf;
        d2f_nxt = s_a.val;
        mul_req_nxt = '{go: 1'b1, div3: 1'b0, a: fz_r, b: df_r};
        state_nxt = ST_HNUM;
      end
      ST_HNUM: begin
        if (mul_rsp.done) begin
          flt     = mul_rsp.ovf;
          num_nxt = mul_rsp.p;
          mul_req_nxt = '{go: 1'b1, div3: 1'b0, a: df_r, b: df_r};
          state_nxt = ST_HDEN;
        end
      end
      ST_HDEN: begin
        if (mul_rsp.done) begin
          flt     = mul_rsp.ovf;
          den_nxt = mul_rsp.p;
          mul_req_nxt = '{go: 1'b1, div3: 1'b0, a: fz_r, b: d2f_r};
          state_nxt = ST_HFD;
        end
      end
      ST_HFD: begin
        if (mul_rsp.done) begin
          s_a = ssub(den_r, div2_tz(mul_rsp.p));
          flt = mul_rsp.ovf | s_a.ovf;
          div_req_nxt = '{go: 1'b1, sqrt: 1'b0, n: num_r, d: s_a.val};
          state_nxt = ST_HDIV;
        end
      end
      // apply the step and test it against the tolerance
      ST_HDIV: begin
        if (div_rsp.done) begin
          s_a   = ssub(z_r, div_rsp.q);
          flt   = div_rsp.ovf | s_a.ovf;
          z_nxt = s_a.val;
          if (mag64(div_rsp.q) < {{(64-TOL_W){1'b0}}, tol_r}) begin
            conv_nxt  = 1'b1;
            state_nxt = ST_FC1;
          end else begin
            state_nxt = ST_LOOP;
          end
        end
      end
      // deflate: c1 = z + a2, c2 = c1 z + a1
      ST_FC1: begin
        s_a    = sadd(z_r, a2_r);
        flt    = s_a.ovf;
        c1_nxt = s_a.val;
        mul_req_nxt = '{go: 1'b1, div3: 1'b0, a: s_a.val, b: z_r};
        state_nxt = ST_FC2;
      end
      ST_FC2: begin
        if (mul_rsp.done) begin
          s_a    = sadd(mul_rsp.p, a1_r);
          flt    = mul_rsp.ovf | s_a.ovf;
          c2_nxt = s_a.val;
          mul_req_nxt = '{go: 1'b1, div3: 1'b0, a: c1_r, b: c1_r};
          state_nxt = ST_FC11;
        end
      end
      ST_FC11: begin
        if (mul_rsp.done) begin
          s_a      = ssub(div4_tz(mul_rsp.p), c2_r);
          s_b      = ssub(64'sd0, c1_r);
          flt      = mul_rsp.ovf | s_a.ovf | s_b.ovf;
          d_nxt    = s_a.val;
          half_nxt = div2_tz(s_b.val);
          state_nxt = ST_FDS;
        end
      end
      ST_FDS: begin
        if (d_r >= 64'sd0) begin
          div_req_nxt = '{go: 1'b1, sqrt: 1'b1, n: d_r, d: DIV_THREE};
        end else begin
          s_a = ssub(64'sd0, d_r);
          flt = s_a.ovf;
          div_req_nxt = '{go: 1'b1, sqrt: 1'b1, n: s_a.val, d: DIV_THREE};
        end
        state_nxt = ST_FSQ;
      end
      // roots of the quadratic, then emit the word
      ST_FSQ: begin
        if (div_rsp.done) begin
          out_word_nxt.root_first = z_r;
          if (d_r >= 64'sd0) begin
            s_a = ssub(half_r, div_rsp.q);
            s_b = sadd(half_r, div_rsp.q);
            flt = s_a.ovf | s_b.ovf;
            out_word_nxt.root_second_re = s_a.val;
            out_word_nxt.root_third_re  = s_b.val;
            out_word_nxt.root_second_im = 64'sd0;
            out_word_nxt.root_third_im  = 64'sd0;
          end else begin
            out_word_nxt.root_second_re = half_r;
            out_word_nxt.root_third_re  = half_r;
            out_word_nxt.root_second_im = div_rsp.q;
            out_word_nxt.root_third_im  = 64'sd0 - div_rsp.q;
          end
          out_word_nxt.converged  = conv_r;
          out_word_nxt.steps_used = it_r;
          out_word_nxt.fault      = fault_r | flt;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    // gather saturation flags of this cycle
    if (state_r != ST_IDLE) fault_nxt = fault_r | flt;
  end

  always_ff @(posedge clk) begin
    ret_r <= ret_nxt;
    it_r <= it_nxt;
    conv_r <= conv_nxt;
    fault_r <= fault_nxt;
    out_word_r <= out_word_nxt;
    a2_r <= a2_nxt;  a1_r <= a1_nxt;  a0_r <= a0_nxt;
    z_r <= z_nxt;    zi_r <= zi_nxt;  d_r <= d_nxt;    pz_r <= pz_nxt;
    z2_r <= z2_nxt;  f_r <= f_nxt;    fz_r <= fz_nxt;
    df_r <= df_nxt;  d2f_r <= d2f_nxt; zz_r <= zz_nxt; a2x2_r <= a2x2_nxt;
    num_r <= num_nxt; den_r <= den_nxt;
    c1_r <= c1_nxt;  c2_r <= c2_nxt;  half_r <= half_nxt;
    cb_r <= cb_nxt;  cb_m_r <= cb_m_nxt; cb_bit_r <= cb_bit_nxt; cb_ovf_r <= cb_ovf_nxt;
    mul_req_r.div3 <= mul_req_nxt.div3;
    mul_req_r.a    <= mul_req_nxt.a;
    mul_req_r.b    <= mul_req_nxt.b;
    div_req_r.sqrt <= div_req_nxt.sqrt;
    div_req_r.n    <= div_req_nxt.n;
    div_req_r.d    <= div_req_nxt.d;
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      tol_r        <= TOL_RESET;
      max_iter_r   <= ITER_RESET;
      out_valid_r  <= 1'b0;
      mul_req_r.go <= 1'b0;
      div_req_r.go <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      tol_r        <= tol_nxt;
      max_iter_r   <= max_iter_nxt;
      out_valid_r  <= out_valid_nxt;
      mul_req_r.go <= mul_req_nxt.go;
      div_req_r.go <= div_req_nxt.go;
    end
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;
  assign cfg_ready = 1'b1;

endmodule

// ===== sim/cubic_roots_halley_deflation_checker.sv =====
`timescale 1ns / 1ps
// Watches the coefficient, root and register channels of the cubic root solver,
// predicts each root word in fixed point and compares it field by field. Depends on chd_pkg.
module cubic_roots_halley_deflation_checker (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic                                busy,
  input  chd_pkg::in_word_t                   in_word,
  input  logic                                out_valid,
  input  chd_pkg::out_word_t                  out_word,
  input  logic                                cfg_valid,
  input  logic                                cfg_ready,
  input  logic [chd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [chd_pkg::CFG_DATA_W-1:0]      cfg_data,
  output int                                  errors,
  output int                                  pending
);
  import chd_pkg::*;

  localparam int F = 40;

  logic [TOL_W-1:0]  tol_q;
  logic [ITER_W-1:0] iter_lim;
  bit                sat_seen;
  out_word_t         roots_q[$];

  function automatic logic [63:0] abs_of(input logic signed [63:0] x);
    return x[63] ? (64'd0 - x) : x;
  endfunction

  function automatic logic signed [63:0] signed_of(input logic [63:0] m, input bit neg,
                                                   inout bit o);
    if (neg) begin
      if (m > 64'h8000_0000_0000_0000) begin
        o = 1'b1;
        return S64_MIN;
      end
      return 64'd0 - m;
    end
    if (m[63]) begin
      o = 1'b1;
      return S64_MAX;
    end
    return m;
  endfunction

  function automatic logic signed [63:0] prod_raw(input logic signed [63:0] a,
                                                  input logic signed [63:0] b, inout bit o);
    logic [127:0] p;
    bit neg;
    p = {64'd0, abs_of(a)} * {64'd0, abs_of(b)};
    neg = a[63] ^ b[63];
    if (p[127:64+F] != 0) begin
      o = 1'b1;
      return neg ? S64_MIN : S64_MAX;
    end
    return signed_of(p[64+F-1:F], neg, o);
  endfunction

  function automatic logic signed [63:0] qmul(input logic signed [63:0] a,
                                              input logic signed [63:0] b);
    bit o;
    logic signed [63:0] r;
    o = 1'b0;
    r = prod_raw(a, b, o);
    if (o) sat_seen = 1'b1;
    return r;
  endfunction

  function automatic logic signed [63:0] qadd(input logic signed [63:0] a,
                                              input logic signed [63:0] b);
    logic signed [64:0] s;
    s = a;
    s = s + b;
    if (s > S64_MAX) begin
      sat_seen = 1'b1;
      return S64_MAX;
    end
    if (s < S64_MIN) begin
      sat_seen = 1'b1;
      return S64_MIN;
    end
    return s[63:0];
  endfunction

  function automatic logic signed [63:0] qsub(input logic signed [63:0] a,
                                              input logic signed [63:0] b);
    logic signed [64:0] s;
    s = a;
    s = s - b;
    if (s > S64_MAX) begin
      sat_seen = 1'b1;
      return S64_MAX;
    end
    if (s < S64_MIN) begin
      sat_seen = 1'b1;
      return S64_MIN;
    end
    return s[63:0];
  endfunction

  function automatic logic signed [63:0] qdiv(input logic signed [63:0] n,
                                              input logic signed [63:0] d);
    logic [127:0] q;
    bit neg;
    bit o;
    logic signed [63:0] r;
    // zero denominator: saturate with the sign of the numerator
    if (d == 0) begin
      sat_seen = 1'b1;
      return (n > 0) ? S64_MAX : ((n < 0) ? S64_MIN : 64'sd0);
    end
    neg = n[63] ^ d[63];
    q = ({64'd0, abs_of(n)} << F) / {64'd0, abs_of(d)};
    if (q[127:64] != 0) begin
      sat_seen = 1'b1;
      return neg ? S64_MIN : S64_MAX;
    end
    o = 1'b0;
    r = signed_of(q[63:0], neg, o);
    if (o) sat_seen = 1'b1;
    return r;
  endfunction

  function automatic logic signed [63:0] qsqrt(input logic signed [63:0] x);
    logic [127:0] n;
    logic [63:0] r;
    logic [63:0] c;
    if (x <= 0) return 64'sd0;
    n = {64'd0, x} << F;
    r = 64'd0;
    for (int b = 63; b >= 0; b--) begin
      c = r | (64'd1 << b);
      if ({64'd0, c} * {64'd0, c} <= n) r = c;
    end
    return r;
  endfunction

  // largest r whose truncated fixed-point cube fits under |x|; no fault raised here
  function automatic logic signed [63:0] qcbrt(input logic signed [63:0] x);
    logic [63:0] m;
    logic signed [63:0] r;
    logic signed [63:0] c;
    logic signed [63:0] sq;
    logic [63:0] cube;
    bit o;
    m = abs_of(x);
    if (m > S64_MAX) m = S64_MAX;
    r = 64'sd0;
    for (int b = 62; b >= 0; b--) begin
      c = r | (64'sd1 <<< b);
      o = 1'b0;
      sq = prod_raw(c, c, o);
      cube = prod_raw(sq, c, o);
      if (!o && cube <= m) r = c;
    end
    return x[63] ? -r : r;
  endfunction

  function automatic logic signed [63:0] cubic_at(input logic signed [63:0] z,
      input logic signed [63:0] a2, input logic signed [63:0] a1,
      input logic signed [63:0] a0);
    logic signed [63:0] z2;
    logic signed [63:0] f;
    z2 = qmul(z, z);
    f = qmul(z2, z);
    f = qadd(f, qmul(a2, z2));
    f = qadd(f, qmul(a1, z));
    return qadd(f, a0);
  endfunction

  function automatic out_word_t solve_roots(input in_word_t w);
    logic signed [63:0] a2, a1, a0, zi, d, z, c1, c2, half, s, fi, sq, t;
    logic signed [63:0] z2, fz, df, d2f, num, den, dz;
    out_word_t r;
    int it;
    bit conv;
    a2 = w.coef_quadratic;
    a1 = w.coef_linear;
    a0 = w.coef_constant;
    sat_seen = 1'b0;
    it = 0;
    conv = 1'b0;
    zi = -(a2 / 3);
    d = qsub(qmul(a2, a2), qadd(qadd(a1, a1), a1));

    // pick the start point from the inflection point and the discriminant
    if (d > 0) begin
      fi = cubic_at(zi, a2, a1, a0);
      sq = qsqrt(d);
      t = qadd(sq, sq) / 3;
      if (fi > 0) z = qsub(zi, t);
      else if (fi < 0) z = qadd(zi, t);
      else z = zi;
    end else if (d < 0) begin
      z = zi;
    end else begin
      z = qsub(zi, qcbrt(cubic_at(zi, a2, a1, a0)));
    end

    // Halley steps until the step falls under the tolerance or the iteration limit is reached
    while (it < iter_lim) begin
      it++;
      z2 = qmul(z, z);
      fz = cubic_at(z, a2, a1, a0);
      df = qadd(qadd(qadd(z2, z2), z2), qadd(qmul(qadd(a2, a2), z), 64'sd0));
      df = qadd(df, a1);
      d2f = qadd(qadd(qadd(z, z), qadd(z, z)), qadd(z, z));
      d2f = qadd(d2f, qadd(a2, a2));
      num = qmul(fz, df);
      den = qsub(qmul(df, df), qmul(fz, d2f) / 2);
      dz = qdiv(num, den);
      z = qsub(z, dz);
      if (abs_of(dz) < {23'd0, tol_q}) begin
        conv = 1'b1;
        break;
      end
    end

    // deflate to a quadratic and take the other two roots
    c1 = qadd(z, a2);
    c2 = qadd(qmul(c1, z), a1);
    d = qsub(qmul(c1, c1) / 4, c2);
    half = qsub(64'sd0, c1) / 2;
    r.root_first = z;
    if (d >= 0) begin
      s = qsqrt(d);
      r.root_second_re = qsub(half, s);
      r.root_third_re = qadd(half, s);
      r.root_second_im = 64'sd0;
      r.root_third_im = 64'sd0;
    end else begin
      s = qsqrt(qsub(64'sd0, d));
      r.root_second_re = half;
      r.root_third_re = half;
      r.root_second_im = s;
      r.root_third_im = -s;
    end
    r.converged = conv;
    r.steps_used = it[7:0];
    r.fault = sat_seen;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [63:0] exp_v,
                             input logic [63:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      $display("%0t: %s mismatch: expected %h, got %h", $time, name, exp_v, act_v);
    end
  endtask

  // track registers, queue a root word per accepted coefficient word, compare results
  always @(posedge clk) begin
    out_word_t exp_w;
    if (!rst_n) begin
      tol_q <= TOL_RESET;
      iter_lim <= ITER_RESET;
      roots_q.delete();
      errors = 0;
      pending = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_TOLERANCE) tol_q <= cfg_data[TOL_W-1:0];
        else if (cfg_index == REG_MAX_ITER) iter_lim <= cfg_data[ITER_W-1:0];
      end
      if (start && !busy) roots_q.push_back(solve_roots(in_word));
      if (out_valid) begin
        if (roots_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected root word %h", $time, out_word);
        end else begin
          exp_w = roots_q.pop_front();
          check_field("root_first", exp_w.root_first, out_word.root_first);
          check_field("root_second_re", exp_w.root_second_re, out_word.root_second_re);
          check_field("root_second_im", exp_w.root_second_im, out_word.root_second_im);
          check_field("root_third_re", exp_w.root_third_re, out_word.root_third_re);
          check_field("root_third_im", exp_w.root_third_im, out_word.root_third_im);
          check_field("converged", exp_w.converged, out_word.converged);
          check_field("steps_used", exp_w.steps_used, out_word.steps_used);
          check_field("fault", exp_w.fault, out_word.fault);
        end
      end
      pending = roots_q.size();
    end
  end

endmodule

// ===== sim/tb_cubic_roots_halley_deflation_top.sv =====
`timescale 1ns / 1ps
// Stimulus and verdict for the cubic root solver: directed and random coefficient
// words over several register settings. Depends on chd_pkg, the block and its checker.
module tb_cubic_roots_halley_deflation_top;
  import chd_pkg::*;

  localparam logic signed [63:0] ONE = 64'sd1 <<< 40;

  logic                  clk;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  in_word_t              in_word;
  logic                  out_valid;
  out_word_t             out_word;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    errors;
  int                    pending;
  int                    sent;

  cubic_roots_halley_deflation_top u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_word(in_word),
    .out_valid(out_valid), .out_word(out_word), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  cubic_roots_halley_deflation_checker u_chk (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_word(in_word),
    .out_valid(out_valid), .out_word(out_word), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(errors), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #(64'd2_000_000_000);
    $display("== FAIL ==");
    $finish;
  end

  // offer one word and hold start until it is taken; optionally idle afterwards
  task automatic send_word(input logic signed [63:0] a2, input logic signed [63:0] a1,
                           input logic signed [63:0] a0, input bit quiet);
    start <= 1'b1;
    in_word <= '{coef_quadratic: a2, coef_linear: a1, coef_constant: a0};
    @(posedge clk);
    while (busy) @(posedge clk);
    sent++;
    if (!quiet && $urandom_range(0, 99) < 15) begin
      start <= 1'b0;
      repeat ($urandom_range(0, 1) ? $urandom_range(1, 8) : $urandom_range(1, 1500))
        @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    repeat (2) @(posedge clk);
    while (busy || pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // write both registers back to back while the block is idle
  task automatic set_regs(input logic [63:0] tol, input logic [63:0] iters);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= REG_TOLERANCE;
    cfg_data <= tol;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_index <= REG_MAX_ITER;
    cfg_data <= iters;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // mostly modest coefficients, some medium, some across the whole range
  function automatic logic signed [63:0] rnd_coef();
    int sel;
    logic signed [63:0] v;
    sel = $urandom_range(0, 99);
    v = {$urandom, $urandom};
    if (sel < 70) return v >>> 19;
    if (sel < 90) return v >>> 11;
    return v;
  endfunction

  task automatic random_run(input int count, input int calm_from, input int calm_to);
    for (int i = 0; i < count; i++)
      send_word(rnd_coef(), rnd_coef(), rnd_coef(), i >= calm_from && i < calm_to);
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_word = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    sent = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed words under the reset settings
    send_word(0, 0, 0, 0);
    send_word(-3 * ONE, 3 * ONE, -ONE, 0);          // triple root, cube-root start
    send_word(0, 0, ONE, 0);                        // flat discriminant, nonzero value
    send_word(-6 * ONE, 11 * ONE, -6 * ONE, 0);     // three real roots
    send_word(0, ONE, 0, 0);                        // complex pair after deflation
    send_word(0, -ONE, 0, 0);                       // value zero at the inflection point
    send_word(0, -ONE, ONE / 2, 0);                 // positive value at the inflection
    send_word(0, -ONE, -ONE / 2, 0);                // negative value at the inflection
    send_word(S64_MAX, S64_MAX, S64_MAX, 0);
    send_word(S64_MIN, S64_MIN, S64_MIN, 0);
    send_word(S64_MAX, S64_MIN, S64_MAX, 0);
    send_word(S64_MIN, S64_MAX, S64_MIN, 0);
    send_word(-1, -1, -1, 0);
    send_word(1, 1, 1, 0);
    send_word(2 * ONE, ONE, 2 * ONE, 0);
    send_word(0, 0, S64_MIN, 0);
    send_word(0, S64_MAX, 0, 0);

    random_run(190, 60, 160);
    set_regs(0, 8);
    random_run(150, 0, 0);
    set_regs(64'h1FF_FFFF_FFFF, 255);
    random_run(100, 0, 0);
    set_regs(64'h100_0000_0000, 1);
    random_run(100, 0, 0);
    set_regs(1, 0);                                 // no steps allowed
    send_word(-6 * ONE, 11 * ONE, -6 * ONE, 0);
    random_run(50, 0, 0);
    set_regs({$urandom, $urandom}, $urandom_range(1, 30));
    random_run(190, 0, 0);
    set_regs(0, 255);
    random_run(5, 0, 0);
    set_regs(1024, 50);
    random_run(10, 0, 0);

    drain();
    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
